### src/mwc_rng_pkg.sv
// ----------------------------------------------------------------------------
// mwc_rng_pkg
// Shared opcodes, command codes and step functions of the multiply-with-carry
// random number generator.
// ----------------------------------------------------------------------------
package mwc_rng_pkg;

  // operation codes on the input channel
  localparam logic [1:0] OP_DRAW = 2'd0;
  localparam logic [1:0] OP_SEED = 2'd1;
  localparam logic [1:0] OP_LOAD = 2'd2;

  // generator constants
  localparam logic [31:0] LCG_MULT   = 32'd69069;
  localparam logic [15:0] MWC_MULT_0 = 16'd36969;
  localparam logic [15:0] MWC_MULT_1 = 16'd18000;
  localparam logic [31:0] WORD_ONE   = 32'd1;

  // commands from controller to datapath
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_DRAW,
    CMD_LOAD,
    CMD_KEEP,
    CMD_SEED_START,
    CMD_STEP,
    CMD_SEED_DONE
  } cmd_e;

  // status from datapath to controller
  typedef struct packed {
    logic seed_done;
  } dp_status_t;

  // one step of the congruential scrambler
  function automatic logic [31:0] lcg_next(input logic [31:0] s);
    logic [31:0] prod;
    prod = LCG_MULT * s;
    return prod + WORD_ONE;
  endfunction

  // one multiply-with-carry step, 16x16 product plus the carry half
  function automatic logic [31:0] mwc_next(input logic [31:0] w, input logic [15:0] mult);
    logic [31:0] prod;
    prod = {16'd0, mult} * {16'd0, w[15:0]};
    return prod + {16'd0, w[31:16]};
  endfunction

  // a zero word would lock the generator
  function automatic logic [31:0] fix_zero(input logic [31:0] w);
    return (w == '0) ? WORD_ONE : w;
  endfunction

endpackage

### src/mwc_rng_ctrl.sv
// ----------------------------------------------------------------------------
// mwc_rng_ctrl
// Handshake control and seed sequencing of the generator.
// ----------------------------------------------------------------------------
module mwc_rng_ctrl
  import mwc_rng_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output cmd_e       cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_SEED
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   accept;
  logic   commit;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = CMD_NONE;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (opcode_i)
            OP_DRAW: cmd_o = CMD_DRAW;
            OP_LOAD: cmd_o = CMD_LOAD;
            OP_SEED: begin
              cmd_o   = CMD_SEED_START;
              state_d = ST_SEED;
            end
            default: cmd_o = CMD_KEEP;
          endcase
        end
      end
      ST_SEED: begin
        if (!status_i.seed_done) begin
          cmd_o = CMD_STEP;
        end else if (out_free) begin
          cmd_o   = CMD_SEED_DONE;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign commit = (cmd_o == CMD_DRAW) || (cmd_o == CMD_LOAD) ||
                  (cmd_o == CMD_KEEP) || (cmd_o == CMD_SEED_DONE);

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### src/mwc_rng_dp.sv
// ----------------------------------------------------------------------------
// mwc_rng_dp
// Generator words, seed scrambler and result register.
// ----------------------------------------------------------------------------
module mwc_rng_dp
  import mwc_rng_pkg::*;
#(
  parameter int unsigned SCRAMBLE_STEPS = 50
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_e        cmd_i,
  input  logic [31:0] value_a_i,
  input  logic [31:0] value_b_i,
  output dp_status_t  status_o,
  output logic [31:0] random_word_o,
  output logic [31:0] state_word_0_o,
  output logic [31:0] state_word_1_o
);

  // two extra steps give the two generator words
  localparam int unsigned TotalSteps = SCRAMBLE_STEPS + 2;
  localparam int unsigned CntW       = $clog2(TotalSteps + 1);
  localparam logic [CntW-1:0] CntLast = CntW'(TotalSteps);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  logic [31:0]     gen0_q, gen0_d;
  logic [31:0]     gen1_q, gen1_d;
  logic [31:0]     rnd_q, rnd_d;
  logic [31:0]     lcg_q, lcg_d;
  logic [31:0]     prev_q, prev_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]     mwc0, mwc1;

  assign mwc0 = mwc_next(gen0_q, MWC_MULT_0);
  assign mwc1 = mwc_next(gen1_q, MWC_MULT_1);

  always_comb begin
    gen0_d = gen0_q;
    gen1_d = gen1_q;
    rnd_d  = rnd_q;
    lcg_d  = lcg_q;
    prev_d = prev_q;
    cnt_d  = cnt_q;
    case (cmd_i)
      CMD_DRAW: begin
        gen0_d = mwc0;
        gen1_d = mwc1;
        rnd_d  = {mwc0[15:0], mwc1[15:0]};
      end
      CMD_LOAD: begin
        gen0_d = fix_zero(value_a_i);
        gen1_d = fix_zero(value_b_i);
        rnd_d  = '0;
      end
      CMD_KEEP: rnd_d = '0;
      CMD_SEED_START: begin
        lcg_d = value_a_i;
        cnt_d = '0;
      end
      CMD_STEP: begin
        lcg_d  = lcg_next(lcg_q);
        prev_d = lcg_q;
        cnt_d  = cnt_q + CntOne;
      end
      CMD_SEED_DONE: begin
        gen0_d = fix_zero(prev_q);
        gen1_d = fix_zero(lcg_q);
        rnd_d  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen0_q <= WORD_ONE;
      gen1_q <= WORD_ONE;
      cnt_q  <= '0;
    end else begin
      gen0_q <= gen0_d;
      gen1_q <= gen1_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rnd_q  <= rnd_d;
    lcg_q  <= lcg_d;
    prev_q <= prev_d;
  end

  assign status_o.seed_done = (cnt_q == CntLast);
  assign random_word_o  = rnd_q;
  assign state_word_0_o = gen0_q;
  assign state_word_1_o = gen1_q;

endmodule

### src/multiply_with_carry_rng_core.sv
// ----------------------------------------------------------------------------
// multiply_with_carry_rng_core
// Two-word multiply-with-carry random number generator with seed and load.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_ready_o) carries an opcode and two words:
//   draw advances both generator words, seed scrambles value_a_i into new
//   words, load writes value_a_i / value_b_i as the words; opcode 3 only
//   reports. output channel (out_valid_o / out_ready_i) returns one result
//   per transfer: the combined draw word (zero unless draw) and both words.
// timing
//   draw, load and the unused opcode: the result is valid the cycle after
//   the input transfer and the next item may transfer then.
//   a sustained stream of draws runs at one per cycle while out_ready_i is high.
//   seed runs the congruential scrambler one step per cycle, SCRAMBLE_STEPS
//   plus two steps, then commits the new words once the output side is
//   free; input held off meanwhile.
// reset
//   both generator words return to 1, no result pending.
// stalls
//   the result register holds while out_ready_i is low; the input side takes
//   a new item in the cycle the pending result leaves.
// ----------------------------------------------------------------------------
module multiply_with_carry_rng_core
  import mwc_rng_pkg::*;
#(
  parameter int unsigned SCRAMBLE_STEPS = 50
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] value_a_i,
  input  logic [31:0] value_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] random_word_o,
  output logic [31:0] state_word_0_o,
  output logic [31:0] state_word_1_o
);

  // command and status between controller and datapath
  cmd_e       cmd;
  dp_status_t status;

  // controller: handshake and seed sequencing
  mwc_rng_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: generator words, scrambler, result register
  mwc_rng_dp #(
    .SCRAMBLE_STEPS (SCRAMBLE_STEPS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .value_a_i      (value_a_i),
    .value_b_i      (value_b_i),
    .status_o       (status),
    .random_word_o  (random_word_o),
    .state_word_0_o (state_word_0_o),
    .state_word_1_o (state_word_1_o)
  );

  // a draw result is the low halves of both new words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && opcode_i == OP_DRAW) |=>
      (out_valid_o && random_word_o[31:16] == state_word_0_o[15:0] &&
       random_word_o[15:0] == state_word_1_o[15:0]))
    else $error("draw result does not match new generator words");

  // a load never leaves a zero word and reports no random word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && opcode_i == OP_LOAD) |=>
      (out_valid_o && state_word_0_o != '0 && state_word_1_o != '0 &&
       random_word_o == '0))
    else $error("load result has a zero word or a random word");

  // seed keeps the input closed while the scrambler runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && opcode_i == OP_SEED) |=> !in_ready_o)
    else $error("input open during seed scramble");

  // seed does not produce a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && opcode_i == OP_SEED) |=> !out_valid_o)
    else $error("seed result appeared before scrambling");

endmodule
